>>> hw/rtl/capture_timestamp_extender_assert.svh
// Assertion macros shared by the capture timestamp extender RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef CAPTURE_TIMESTAMP_EXTENDER_ASSERT_SVH
`define CAPTURE_TIMESTAMP_EXTENDER_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, disabled during reset
`define CTE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset
`define CTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CTE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define CTE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> hw/rtl/cte_pkg.sv
// Package for the capture timestamp extender: widths, codes, control struct.
// No dependencies; used by the interfaces, cte_core and the top level.
`default_nettype none

package cte_pkg;

    localparam int CNT_W   = 16;
    localparam int STAMP_W = 2 * CNT_W;
    localparam int PEND_W  = 2;

    // Bit positions in the pending mask
    localparam int PEND_RISE_BIT = 0;
    localparam int PEND_FALL_BIT = 1;

    // Word kinds on the input channel
    typedef enum logic {
        MODE_EVENT = 1'b0,
        MODE_POLL  = 1'b1
    } t_mode;

    // Accept strobes from the handshake logic to the core
    typedef struct packed {
        logic ev_acc;
        logic poll_acc;
    } t_cte_ctrl;

    // Extended stamp: a capture at or below the timer value was taken after the wrap
    function automatic logic [STAMP_W-1:0] make_stamp(
        input logic [CNT_W-1:0] cnt,
        input logic [CNT_W-1:0] cap,
        input logic [CNT_W-1:0] tv
    );
        logic [CNT_W-1:0] hi;
        hi = (cap <= tv) ? cnt + CNT_W'(1) : cnt;
        return {hi, cap};
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cte_if.sv
// Valid/ready channel interfaces for the capture timestamp extender.
// Depends on cte_pkg for field widths.
`default_nettype none

// Input channel: overflow events and polls
interface cte_evt_if;
    import cte_pkg::*;

    logic               valid;
    logic               ready;
    logic               mode;
    logic               overflow_seen;
    logic               rising_loaded;
    logic               falling_loaded;
    logic [CNT_W-1:0]   timer_value;
    logic [CNT_W-1:0]   rising_capture;
    logic [CNT_W-1:0]   falling_capture;

    modport source (
        output valid, mode, overflow_seen, rising_loaded, falling_loaded,
               timer_value, rising_capture, falling_capture,
        input  ready
    );
    modport sink (
        input  valid, mode, overflow_seen, rising_loaded, falling_loaded,
               timer_value, rising_capture, falling_capture,
        output ready
    );
endinterface

// Result channel: poll replies
interface cte_res_if;
    import cte_pkg::*;

    logic               valid;
    logic               ready;
    logic [PEND_W-1:0]  pending_mask;
    logic [STAMP_W-1:0] rising_stamp;
    logic [STAMP_W-1:0] falling_stamp;

    modport source (
        output valid, pending_mask, rising_stamp, falling_stamp,
        input  ready
    );
    modport sink (
        input  valid, pending_mask, rising_stamp, falling_stamp,
        output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/capture_timestamp_extender.sv
// A poll word's reply is registered into the output register as the poll is accepted.
// Throughput: one word per cycle; an event is taken even while a reply waits,
// a poll waits only while the single output register is full and not drained.
// Reset (synchronous, active low) clears the overflow count, both stamps,
// the pending bits and the output valid flag.
`default_nettype none
`include "capture_timestamp_extender_assert.svh"

module capture_timestamp_extender (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cte_evt_if.sink   i_evt,
    cte_res_if.source o_res
);
    import cte_pkg::*;

    t_cte_ctrl          w_ctrl;
    logic               w_is_poll;
    logic [PEND_W-1:0]  w_mask;
    logic [STAMP_W-1:0] w_rise;
    logic [STAMP_W-1:0] w_fall;
    logic               r_out_valid, n_out_valid;
    logic [PEND_W-1:0]  r_mask;
    logic [STAMP_W-1:0] r_rise;
    logic [STAMP_W-1:0] r_fall;

    // Handshake: only a poll needs room in the output register
    assign w_is_poll     = (i_evt.mode == MODE_POLL);
    assign i_evt.ready   = !w_is_poll || !r_out_valid || o_res.ready;
    assign w_ctrl.ev_acc   = i_evt.valid && i_evt.ready && !w_is_poll;
    assign w_ctrl.poll_acc = i_evt.valid && i_evt.ready && w_is_poll;

    cte_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (w_ctrl),
        .i_overflow_seen   (i_evt.overflow_seen),
        .i_rising_loaded   (i_evt.rising_loaded),
        .i_falling_loaded  (i_evt.falling_loaded),
        .i_timer_value     (i_evt.timer_value),
        .i_rising_capture  (i_evt.rising_capture),
        .i_falling_capture (i_evt.falling_capture),
        .o_pending_mask    (w_mask),
        .o_rising_stamp    (w_rise),
        .o_falling_stamp   (w_fall)
    );

    // Output valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_ctrl.poll_acc) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload, loaded on a poll
    always_ff @(posedge i_clk) begin
        if (w_ctrl.poll_acc) begin
            r_mask <= w_mask;
            r_rise <= w_rise;
            r_fall <= w_fall;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.pending_mask  = r_mask;
    assign o_res.rising_stamp  = r_rise;
    assign o_res.falling_stamp = r_fall;

    // Checks
    `CTE_ASSERT_NEXT(a_poll_reply, i_clk, i_rst_n, w_ctrl.poll_acc,
        r_out_valid, "poll accepted but no reply registered")
    `CTE_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !i_evt.ready,
        r_out_valid && !o_res.ready && w_is_poll, "input stalled without a full output")
    `CTE_ASSERT_NEXT(a_reply_hold, i_clk, i_rst_n, o_res.valid && !o_res.ready,
        o_res.valid && $stable(r_mask) && $stable(r_rise) && $stable(r_fall),
        "reply dropped or changed while stalled")

endmodule

`default_nettype wire

>>> hw/rtl/cte_core.sv
// Stamp core: overflow counter, stored rising/falling stamps and pending bits.
// Depends on cte_pkg and capture_timestamp_extender_assert.svh.
`default_nettype none
`include "capture_timestamp_extender_assert.svh"

module cte_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cte_pkg::t_cte_ctrl          i_ctrl,
    input  logic                        i_overflow_seen,
    input  logic                        i_rising_loaded,
    input  logic                        i_falling_loaded,
    input  logic [cte_pkg::CNT_W-1:0]   i_timer_value,
    input  logic [cte_pkg::CNT_W-1:0]   i_rising_capture,
    input  logic [cte_pkg::CNT_W-1:0]   i_falling_capture,
    output logic [cte_pkg::PEND_W-1:0]  o_pending_mask,
    output logic [cte_pkg::STAMP_W-1:0] o_rising_stamp,
    output logic [cte_pkg::STAMP_W-1:0] o_falling_stamp
);
    import cte_pkg::*;

    logic [CNT_W-1:0]   r_ovf_cnt,   n_ovf_cnt;
    logic [STAMP_W-1:0] r_rise_time, n_rise_time;
    logic [STAMP_W-1:0] r_fall_time, n_fall_time;
    logic [PEND_W-1:0]  r_pending,   n_pending;
    logic               w_ovf_evt;

    // Of the events, only those with the overflow flag set touch the state
    assign w_ovf_evt = i_ctrl.ev_acc && i_overflow_seen;

    // Next state
    always_comb begin
        n_ovf_cnt   = r_ovf_cnt;
        n_rise_time = r_rise_time;
        n_fall_time = r_fall_time;
        n_pending   = r_pending;
        if (i_ctrl.poll_acc) begin
            n_pending = '0;
        end else if (w_ovf_evt) begin
            if (i_rising_loaded) begin
                n_rise_time = make_stamp(r_ovf_cnt, i_rising_capture, i_timer_value);
                n_pending[PEND_RISE_BIT] = 1'b1;
            end
            if (i_falling_loaded) begin
                n_fall_time = make_stamp(r_ovf_cnt, i_falling_capture, i_timer_value);
                n_pending[PEND_FALL_BIT] = 1'b1;
            end
            n_ovf_cnt = r_ovf_cnt + CNT_W'(1);
        end
    end

    // State registers, all cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovf_cnt   <= '0;
            r_rise_time <= '0;
            r_fall_time <= '0;
            r_pending   <= '0;
        end else begin
            r_ovf_cnt   <= n_ovf_cnt;
            r_rise_time <= n_rise_time;
            r_fall_time <= n_fall_time;
            r_pending   <= n_pending;
        end
    end

    // Poll reply reflects state before this word
    assign o_pending_mask  = r_pending;
    assign o_rising_stamp  = r_rise_time;
    assign o_falling_stamp = r_fall_time;

    // Checks
    `CTE_ASSERT_NEXT(a_cnt_inc, i_clk, i_rst_n, w_ovf_evt,
        r_ovf_cnt == $past(r_ovf_cnt) + CNT_W'(1), "overflow count did not advance")
    `CTE_ASSERT_NEXT(a_poll_clr, i_clk, i_rst_n, i_ctrl.poll_acc,
        r_pending == '0, "pending bits not cleared by poll")
    `CTE_ASSERT_NEXT(a_idle_hold, i_clk, i_rst_n, !w_ovf_evt && !i_ctrl.poll_acc,
        $stable(r_pending) && $stable(r_ovf_cnt), "state changed without a word")

endmodule

`default_nettype wire

>>> dv/tb_capture_timestamp_extender.sv
// Self-checking testbench for capture_timestamp_extender: directed table, then random words.
// Depends on cte_pkg, cte_evt_if / cte_res_if and the RTL top level; nothing else.
`timescale 1ns / 100ps

module tb_capture_timestamp_extender;
    import cte_pkg::*;

    // One word on the input channel
    typedef struct packed {
        t_mode              mode;
        logic               overflow_seen;
        logic               rising_loaded;
        logic               falling_loaded;
        logic [CNT_W-1:0]   timer_value;
        logic [CNT_W-1:0]   rising_capture;
        logic [CNT_W-1:0]   falling_capture;
    } t_evt_word;

    // One poll reply
    typedef struct packed {
        logic [PEND_W-1:0]  pending_mask;
        logic [STAMP_W-1:0] rising_stamp;
        logic [STAMP_W-1:0] falling_stamp;
    } t_reply;

    // Directed step: a word, plus a hand-written reply where one is pinned
    typedef struct {
        t_evt_word word;
        bit        pinned;
        t_reply    reply;
    } t_step_row;

    localparam int RANDOM_WORDS = 1400;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cte_evt_if evt_ch ();
    cte_res_if res_ch ();

    capture_timestamp_extender u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt_ch),
        .o_res   (res_ch)
    );

    always #1 i_clk = ~i_clk;

    // Shadow of the block's state
    logic [CNT_W-1:0]   ovf_count;
    logic [STAMP_W-1:0] rise_stamp;
    logic [STAMP_W-1:0] fall_stamp;
    logic [PEND_W-1:0]  pend_bits;
    t_reply             replies_due[$];

    // Reply pinned to the word currently on the channel
    logic   pin_active;
    t_reply pin_reply;

    t_step_row   directed_rows[$];
    int unsigned burst_left;
    int unsigned fail_count;
    int unsigned events_taken;
    int unsigned ignored_taken;
    int unsigned polls_taken;
    int unsigned replies_checked;
    int unsigned count_wraps;
    logic [9:0]  stall_phase;

    // Upper half is count + 1 when the capture sits at or below the timer (taken after the wrap)
    function automatic logic [STAMP_W-1:0] extend_capture(input logic [CNT_W-1:0] cnt,
                                                          input logic [CNT_W-1:0] cap,
                                                          input logic [CNT_W-1:0] tv);
        logic [CNT_W-1:0] upper;
        upper = (cap <= tv) ? cnt + 1'b1 : cnt;
        return {upper, cap};
    endfunction

    // Update the shadow state for one accepted word; a poll queues its reply
    task automatic absorb_word(input t_evt_word w, input logic pinned, input t_reply pinned_reply);
        t_reply r;
        if (w.mode == MODE_POLL) begin
            r.pending_mask  = pend_bits;
            r.rising_stamp  = rise_stamp;
            r.falling_stamp = fall_stamp;
            replies_due.push_back(pinned ? pinned_reply : r);
            pend_bits = '0;
            polls_taken++;
        end else if (!w.overflow_seen) begin
            ignored_taken++;
        end else begin
            if (w.rising_loaded) begin
                rise_stamp = extend_capture(ovf_count, w.rising_capture, w.timer_value);
                pend_bits[PEND_RISE_BIT] = 1'b1;
            end
            if (w.falling_loaded) begin
                fall_stamp = extend_capture(ovf_count, w.falling_capture, w.timer_value);
                pend_bits[PEND_FALL_BIT] = 1'b1;
            end
            ovf_count = ovf_count + 1'b1;
            if (ovf_count == '0)
                count_wraps++;
            events_taken++;
        end
    endtask

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin : monitor
        t_evt_word w;
        t_reply    want;
        if (i_rst_n) begin
            if (evt_ch.valid && evt_ch.ready) begin
                w.mode            = t_mode'(evt_ch.mode);
                w.overflow_seen   = evt_ch.overflow_seen;
                w.rising_loaded   = evt_ch.rising_loaded;
                w.falling_loaded  = evt_ch.falling_loaded;
                w.timer_value     = evt_ch.timer_value;
                w.rising_capture  = evt_ch.rising_capture;
                w.falling_capture = evt_ch.falling_capture;
                absorb_word(w, pin_active, pin_reply);
            end
            if (res_ch.valid && res_ch.ready) begin
                if (replies_due.size() == 0) begin
                    $error("reply with no poll outstanding: mask %b rise %h fall %h",
                           res_ch.pending_mask, res_ch.rising_stamp, res_ch.falling_stamp);
                    fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    replies_checked++;
                    if (res_ch.pending_mask !== want.pending_mask) begin
                        $error("pending_mask: expected %b, got %b",
                               want.pending_mask, res_ch.pending_mask);
                        fail_count++;
                    end
                    if (res_ch.rising_stamp !== want.rising_stamp) begin
                        $error("rising_stamp: expected %h, got %h",
                               want.rising_stamp, res_ch.rising_stamp);
                        fail_count++;
                    end
                    if (res_ch.falling_stamp !== want.falling_stamp) begin
                        $error("falling_stamp: expected %h, got %h",
                               want.falling_stamp, res_ch.falling_stamp);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Receiver: stall pattern changes with the top two bits of the phase counter
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1'b1;
        case (stall_phase[9:8])
            2'd0: res_ch.ready <= 1'b1;
            2'd1: res_ch.ready <= 1'($urandom_range(0, 1));
            2'd2: res_ch.ready <= ($urandom_range(0, 3) == 0);
            default: res_ch.ready <= ~stall_phase[2];
        endcase
    end

    // Drive a word at the falling edge and hold it until accepted
    task automatic send_word(input t_evt_word w, input bit pinned, input t_reply reply);
        @(negedge i_clk);
        evt_ch.valid           <= 1'b1;
        evt_ch.mode            <= w.mode;
        evt_ch.overflow_seen   <= w.overflow_seen;
        evt_ch.rising_loaded   <= w.rising_loaded;
        evt_ch.falling_loaded  <= w.falling_loaded;
        evt_ch.timer_value     <= w.timer_value;
        evt_ch.rising_capture  <= w.rising_capture;
        evt_ch.falling_capture <= w.falling_capture;
        pin_active             <= pinned;
        pin_reply              <= reply;
        do @(posedge i_clk); while (!(evt_ch.valid && evt_ch.ready));
    endtask

    task automatic idle_for(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            evt_ch.valid <= 1'b0;
        end
    endtask

    // Sender bursts: random length, random gap, gap-free stretches now and then
    task automatic pace_sender();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            idle_for($urandom_range(1, 6));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 12);
        end
    endtask

    // Hold off until every poll has its reply
    task automatic drain_replies();
        @(negedge i_clk);
        evt_ch.valid <= 1'b0;
        while (replies_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic add_event(input logic ovf, input logic rl, input logic fl,
                             input logic [CNT_W-1:0] tv, input logic [CNT_W-1:0] rc,
                             input logic [CNT_W-1:0] fc);
        t_step_row row;
        row.word   = {MODE_EVENT, ovf, rl, fl, tv, rc, fc};
        row.pinned = 1'b0;
        row.reply  = '0;
        directed_rows.push_back(row);
    endtask

    // Poll with its ignored fields all ones or all zeros
    task automatic add_poll(input bit ones, input bit pinned, input logic [PEND_W-1:0] mask,
                            input logic [STAMP_W-1:0] rise, input logic [STAMP_W-1:0] fall);
        t_step_row row;
        row.word      = ones ? '1 : '0;
        row.word.mode = MODE_POLL;
        row.pinned    = pinned;
        row.reply     = {mask, rise, fall};
        directed_rows.push_back(row);
    endtask

    // Capture values biased towards the compare boundary
    function automatic logic [CNT_W-1:0] near_capture(input logic [CNT_W-1:0] tv);
        case ($urandom_range(0, 5))
            0: return tv;
            1: return tv - 1'b1;
            2: return tv + 1'b1;
            3: return '0;
            4: return '1;
            default: return CNT_W'($urandom);
        endcase
    endfunction

    function automatic t_evt_word random_word(input bit event_only);
        t_evt_word  w;
        int unsigned pick;
        pick                = event_only ? 99 : $urandom_range(0, 99);
        w.timer_value       = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(0, 1) * 16'hFFFF)
                                                          : CNT_W'($urandom);
        w.rising_capture    = near_capture(w.timer_value);
        w.falling_capture   = near_capture(w.timer_value);
        w.rising_loaded     = 1'($urandom_range(0, 1));
        w.falling_loaded    = 1'($urandom_range(0, 1));
        w.overflow_seen     = (pick >= 35);
        w.mode              = (pick < 25) ? MODE_POLL : MODE_EVENT;
        return w;
    endfunction

    initial begin : stimulus
        t_evt_word        w;
        t_reply           no_reply;
        int unsigned      counted;
        logic [CNT_W-1:0] tv;

        no_reply             = '0;
        i_rst_n              = 1'b0;
        evt_ch.valid         = 1'b0;
        evt_ch.mode          = MODE_EVENT;
        evt_ch.overflow_seen = 1'b0;
        evt_ch.rising_loaded = 1'b0;
        evt_ch.falling_loaded  = 1'b0;
        evt_ch.timer_value     = '0;
        evt_ch.rising_capture  = '0;
        evt_ch.falling_capture = '0;
        res_ch.ready         = 1'b1;
        stall_phase          = '0;
        pin_active           = 1'b0;
        pin_reply            = '0;
        ovf_count            = '0;
        rise_stamp           = '0;
        fall_stamp           = '0;
        pend_bits            = '0;
        burst_left           = 0;
        fail_count           = 0;
        events_taken         = 0;
        ignored_taken        = 0;
        polls_taken          = 0;
        replies_checked      = 0;
        count_wraps          = 0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: reset state, ignored events, compare boundary, stale stamps
        add_poll(0, 1, 2'b00, 32'h0000_0000, 32'h0000_0000);
        add_event(0, 1, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_poll(1, 1, 2'b00, 32'h0000_0000, 32'h0000_0000);
        add_event(1, 1, 0, 16'h0000, 16'h0000, 16'hFFFF);
        add_poll(0, 1, 2'b01, 32'h0001_0000, 32'h0000_0000);
        add_event(1, 0, 1, 16'h0000, 16'hABCD, 16'hFFFF);
        add_poll(1, 1, 2'b10, 32'h0001_0000, 32'h0001_FFFF);
        add_poll(0, 1, 2'b00, 32'h0001_0000, 32'h0001_FFFF);
        add_event(1, 1, 1, 16'hFFFF, 16'hFFFF, 16'h0000);
        add_event(1, 0, 0, 16'h5A5A, 16'h0000, 16'h0000);
        add_event(0, 1, 1, 16'h0000, 16'h0000, 16'h0000);
        add_poll(0, 1, 2'b11, 32'h0003_FFFF, 32'h0003_0000);
        add_event(1, 1, 1, 16'h8000, 16'h8001, 16'h7FFF);
        add_event(1, 1, 0, 16'h1234, 16'h1234, 16'h4321);
        add_poll(1, 1, 2'b11, 32'h0006_1234, 32'h0005_7FFF);
        add_poll(0, 0, 2'b00, 32'h0000_0000, 32'h0000_0000);
        add_event(1, 1, 1, 16'h0001, 16'h0000, 16'h0002);
        add_poll(1, 0, 2'b00, 32'h0000_0000, 32'h0000_0000);
        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].word, directed_rows[i].pinned, directed_rows[i].reply);
            pace_sender();
        end
        drain_replies();

        // Random words, ignored events counted too
        counted = 0;
        while (counted < RANDOM_WORDS) begin
            w = random_word(1'b0);
            send_word(w, 1'b0, no_reply);
            counted++;
            pace_sender();

            if (counted % 300 == 299)
                drain_replies();

            // Halfway: captures just below, at and just above the timer, back to back
            if (counted == RANDOM_WORDS / 2) begin
                drain_replies();
                tv = CNT_W'($urandom_range(1, 16'hFFFE));
                send_word({MODE_EVENT, 1'b1, 1'b1, 1'b0, tv, tv - 1'b1, 16'h0000},
                          1'b0, no_reply);
                send_word({MODE_EVENT, 1'b1, 1'b0, 1'b0, tv, 16'h0000, 16'h0000},
                          1'b0, no_reply);
                send_word({MODE_EVENT, 1'b1, 1'b1, 1'b1, tv, tv, tv + 1'b1}, 1'b0, no_reply);
                send_word({MODE_POLL, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000},
                          1'b0, no_reply);
                counted += 4;
            end
        end

        drain_replies();
        repeat (4) @(posedge i_clk);

        $display("Run covered %0d overflow events, %0d ignored events and %0d polls;",
                 events_taken, ignored_taken, polls_taken);
        $display("%0d replies checked, overflow count wrapped %0d time(s), %0d mismatches.",
                 replies_checked, count_wraps, fail_count);
        if (fail_count == 0) begin
            $display("[capture_timestamp_extender] OK");
        end else begin
            $display("[capture_timestamp_extender] ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("[capture_timestamp_extender] ERROR");
        $finish;
    end

endmodule
